### design/apn_pkg.sv
// Package for the absolute path normalizer: sizes, character codes, command and
// port structs shared by the front, the command queue, the back and the top level.
// Depends on nothing.
`default_nettype none

package apn_pkg;

   // Stack and name sizes.
   localparam int MAX_DEPTH  = 16;
   localparam int NAME_BYTES = 32;
   localparam int OUT_BYTES  = 64;

   localparam int BYTE_W  = 8;
   localparam int CAP_W   = 7;
   localparam int SLOT_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam int LEN_W   = $clog2(NAME_BYTES);
   localparam int TOTAL_W = $clog2(MAX_DEPTH * NAME_BYTES + 1);
   localparam int CMP_W   = (TOTAL_W + 1 > CAP_W) ? TOTAL_W + 1 : CAP_W;

   localparam int STORE_AW    = SLOT_W + LEN_W;
   localparam int STORE_DEPTH = 1 << STORE_AW;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
   localparam logic [CAP_W-1:0] OUT_CAP   = CAP_W'(OUT_BYTES);
   localparam logic [CAP_W-1:0] MIN_CAP   = CAP_W'(2);

   localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'h7F;
   localparam logic [BYTE_W-1:0] ERROR_BYTE = 8'h00;

   typedef enum logic [1:0] {
      CMD_ERROR,
      CMD_ROOT,
      CMD_WALK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [TOTAL_W-1:0]   total;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [BYTE_W-1:0]   data;
   } store_wr_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
   } store_rd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SLASH,
      BK_BYTES
   } bk_state_type;

endpackage

`default_nettype wire

### design/apn_req_if.sv
// Request channel of the path normalizer: one path byte and its last flag.
// Depends on nothing.
`default_nettype none

interface apn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] path_byte;
   logic       is_last;

   modport source (output valid, output path_byte, output is_last, input ready);
   modport sink   (input valid, input path_byte, input is_last, output ready);
endinterface

`default_nettype wire

### design/apn_rsp_if.sv
// Response channel of the path normalizer: one output byte, status and end flag.
// Depends on nothing.
`default_nettype none

interface apn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       status;
   logic       end_of_path;

   modport source (output valid, output out_byte, output status, output end_of_path,
                   input ready);
   modport sink   (input valid, input out_byte, input status, input end_of_path,
                   output ready);
endinterface

`default_nettype wire

### design/apn_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module apn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/apn_front.sv
// Front of the path normalizer: takes path bytes, tracks the current component,
// keeps the component stack bookkeeping and issues one command per path.
// Depends on apn_pkg and apn_req_if.
`default_nettype none

module apn_front
   import apn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   apn_req_if.sink                req_if,
   input  wire logic              stall,
   input  wire logic [CAP_W-1:0]  out_capacity,
   output      store_wr_type      store_wr,
   output      logic              cmd_push,
   output      cmd_type           cmd,
   input  wire logic [SLOT_W-1:0] len_rd_slot,
   output      logic [LEN_W-1:0]  len_rd_len
);

   logic                first_ff,  first_in;
   logic                inv_ff,    inv_in;
   logic [LEN_W-1:0]    len_ff,    len_in;
   logic [BYTE_W-1:0]   c0_ff,     c0_in;
   logic [BYTE_W-1:0]   c1_ff,     c1_in;
   logic [DEPTH_W-1:0]  depth_ff,  depth_in;
   logic [TOTAL_W-1:0]  total_ff,  total_in;
   logic [LEN_W-1:0]    lengths_ff [MAX_DEPTH];
   logic [TOTAL_W-1:0]  prefix_ff  [MAX_DEPTH];

   logic                take;
   logic [BYTE_W-1:0]   byte_v;
   logic                inv_a, inv_b, inv_c;
   logic                is_slash, is_ctrl, at_limit, append;
   logic [LEN_W-1:0]    len_a;
   logic [BYTE_W-1:0]   c0_a, c1_a;
   logic                close_req, is_dot, is_dotdot, real_comp, stack_full;
   logic                do_push, do_pop;
   logic [DEPTH_W-1:0]  depth_dec;
   logic [SLOT_W-1:0]   slot;
   logic [DEPTH_W-1:0]  depth_c;
   logic [TOTAL_W-1:0]  total_c;
   logic [CAP_W-1:0]    cap_eff;
   logic [CMP_W-1:0]    need;
   logic                too_long;

   assign req_if.ready = !stall;
   assign take         = req_if.valid && req_if.ready;
   assign byte_v       = req_if.path_byte;
   assign slot         = depth_ff[SLOT_W-1:0];
   assign depth_dec    = depth_ff - 1'b1;
   assign len_rd_len   = lengths_ff[len_rd_slot];

   always_comb begin
      inv_a    = inv_ff || (first_ff && (byte_v != CHAR_SLASH));
      is_slash = (byte_v == CHAR_SLASH);
      is_ctrl  = (byte_v < CHAR_SPACE) || (byte_v == CHAR_DEL);
      at_limit = (len_ff == LEN_W'(NAME_BYTES - 1));
      append   = !inv_a && !is_slash && !is_ctrl && !at_limit;
      inv_b    = inv_a || (!is_slash && (is_ctrl || at_limit));
      len_a    = append ? len_ff + 1'b1 : len_ff;
      c0_a     = (append && (len_ff == '0)) ? byte_v : c0_ff;
      c1_a     = (append && (len_ff == LEN_W'(1))) ? byte_v : c1_ff;

      // A separator or the end of the path closes the component.
      close_req  = !inv_b && (is_slash || req_if.is_last);
      is_dot     = (len_a == LEN_W'(1)) && (c0_a == CHAR_DOT);
      is_dotdot  = (len_a == LEN_W'(2)) && (c0_a == CHAR_DOT) && (c1_a == CHAR_DOT);
      real_comp  = (len_a != '0) && !is_dot && !is_dotdot;
      stack_full = (depth_ff == DEPTH_W'(MAX_DEPTH));
      do_pop     = close_req && is_dotdot && (depth_ff != '0);
      do_push    = close_req && real_comp && !stack_full;
      inv_c      = inv_b || (close_req && real_comp && stack_full);

      depth_c = depth_ff;
      total_c = total_ff;
      if (do_push) begin
         depth_c = depth_ff + 1'b1;
         total_c = total_ff + TOTAL_W'(len_a) + 1'b1;
      end else if (do_pop) begin
         depth_c = depth_dec;
         total_c = prefix_ff[depth_dec[SLOT_W-1:0]];
      end

      // Bytes of the open component go straight into the slot above the top.
      store_wr.en   = take && append && !stack_full;
      store_wr.addr = {slot, len_ff};
      store_wr.data = byte_v;

      cap_eff  = (out_capacity > OUT_CAP) ? OUT_CAP : out_capacity;
      need     = CMP_W'(total_c) + 1'b1;
      too_long = need > CMP_W'(cap_eff);

      cmd_push  = take && req_if.is_last;
      cmd.total = total_c;
      if (inv_c || (cap_eff < MIN_CAP)) begin
         cmd.kind = CMD_ERROR;
      end else if (depth_c == '0) begin
         cmd.kind = CMD_ROOT;
      end else if (too_long) begin
         cmd.kind = CMD_ERROR;
      end else begin
         cmd.kind = CMD_WALK;
      end

      first_in = first_ff;
      inv_in   = inv_ff;
      len_in   = len_ff;
      c0_in    = c0_ff;
      c1_in    = c1_ff;
      depth_in = depth_ff;
      total_in = total_ff;
      if (take) begin
         if (req_if.is_last) begin
            first_in = 1'b1;
            inv_in   = 1'b0;
            len_in   = '0;
            depth_in = '0;
            total_in = '0;
         end else begin
            first_in = 1'b0;
            inv_in   = inv_c;
            len_in   = close_req ? '0 : len_a;
            c0_in    = c0_a;
            c1_in    = c1_a;
            depth_in = depth_c;
            total_in = total_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         inv_ff   <= 1'b0;
         len_ff   <= '0;
         depth_ff <= '0;
         total_ff <= '0;
      end else begin
         first_ff <= first_in;
         inv_ff   <= inv_in;
         len_ff   <= len_in;
         depth_ff <= depth_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      c0_ff <= c0_in;
      c1_ff <= c1_in;
      if (take && do_push) begin
         lengths_ff[slot] <= len_a;
         prefix_ff[slot]  <= total_ff;
      end
   end

endmodule

`default_nettype wire

### design/apn_cmd_queue.sv
// Short command queue between the front and the back of the path normalizer.
// Depends on apn_pkg.
`default_nettype none

module apn_cmd_queue
   import apn_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output      cmd_type pop_cmd,
   output q_status_type status
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;
   logic              do_push, do_pop;

   always_comb begin
      status.valid = (count_ff != '0);
      status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
      do_push      = push && !status.full;
      do_pop       = pop && status.valid;
      pop_cmd      = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### design/apn_back.sv
// Back of the path normalizer: runs commands from the queue, walking the component
// store one byte per cycle, unless rsp_if stalls, into a registered response stage.
// Depends on apn_pkg and apn_rsp_if.
`default_nettype none

module apn_back
   import apn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire cmd_type           cmd,
   output      logic              cmd_pop,
   output      logic [SLOT_W-1:0] len_rd_slot,
   input  wire logic [LEN_W-1:0]  len_rd_len,
   output      store_rd_type      store_rd,
   input  wire logic [BYTE_W-1:0] store_rd_data,
   output      logic              busy,
   apn_rsp_if.source              rsp_if
);

   bk_state_type       state_ff, state_in;
   logic [SLOT_W-1:0]  slot_ff,  slot_in;
   logic [LEN_W-1:0]   k_ff,     k_in;
   logic [TOTAL_W-1:0] cnt_ff,   cnt_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   // Stage that waits for the registered store read.
   logic               p1_valid_ff, p1_valid_in;
   logic               p1_slash_ff, p1_slash_in;
   logic               p1_end_ff,   p1_end_in;

   logic               rsp_valid_ff,  rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff,   rsp_byte_in;
   logic               rsp_status_ff, rsp_status_in;
   logic               rsp_end_ff,    rsp_end_in;

   logic               out_free, issue, end_now, last_byte;

   assign len_rd_slot        = slot_ff;
   assign busy               = (state_ff != BK_IDLE) || p1_valid_ff;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_byte    = rsp_byte_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.end_of_path = rsp_end_ff;

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      k_in          = k_ff;
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      p1_valid_in   = p1_valid_ff;
      p1_slash_in   = p1_slash_ff;
      p1_end_in     = p1_end_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_end_in    = rsp_end_ff;
      cmd_pop       = 1'b0;
      store_rd.en   = 1'b0;
      store_rd.addr = {slot_ff, k_ff};

      out_free  = !rsp_valid_ff || rsp_if.ready;
      issue     = (state_ff != BK_IDLE) && (!p1_valid_ff || out_free);
      end_now   = ((cnt_ff + 1'b1) == total_ff);
      last_byte = ((k_ff + 1'b1) == len_rd_len);

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (p1_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = p1_slash_ff ? CHAR_SLASH : store_rd_data;
         rsp_status_in = 1'b0;
         rsp_end_in    = p1_end_ff;
         p1_valid_in   = 1'b0;
      end

      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && !p1_valid_ff && out_free) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  CMD_ROOT: begin
                     rsp_valid_in  = 1'b1;
                     rsp_byte_in   = CHAR_SLASH;
                     rsp_status_in = 1'b0;
                     rsp_end_in    = 1'b1;
                  end
                  CMD_WALK: begin
                     state_in = BK_SLASH;
                     slot_in  = '0;
                     k_in     = '0;
                     cnt_in   = '0;
                     total_in = cmd.total;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_byte_in   = ERROR_BYTE;
                     rsp_status_in = 1'b1;
                     rsp_end_in    = 1'b1;
                  end
               endcase
            end
         end
         BK_SLASH: begin
            if (issue) begin
               p1_valid_in = 1'b1;
               p1_slash_in = 1'b1;
               p1_end_in   = end_now;
               cnt_in      = cnt_ff + 1'b1;
               if (end_now) begin
                  state_in = BK_IDLE;
               end else if (len_rd_len == '0) begin
                  slot_in = slot_ff + 1'b1;
               end else begin
                  state_in = BK_BYTES;
                  k_in     = '0;
               end
            end
         end
         BK_BYTES: begin
            if (issue) begin
               store_rd.en = 1'b1;
               p1_valid_in = 1'b1;
               p1_slash_in = 1'b0;
               p1_end_in   = end_now;
               cnt_in      = cnt_ff + 1'b1;
               if (end_now) begin
                  state_in = BK_IDLE;
               end else if (last_byte) begin
                  state_in = BK_SLASH;
                  slot_in  = slot_ff + 1'b1;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      k_ff          <= k_in;
      cnt_ff        <= cnt_in;
      total_ff      <= total_in;
      p1_slash_ff   <= p1_slash_in;
      p1_end_ff     <= p1_end_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_end_ff    <= rsp_end_in;
   end

endmodule

`default_nettype wire

### design/absolute_path_normalizer.sv
// Absolute path normalizer, top level.
// Requests on req_if carry one path byte each, with is_last on the final byte of a
// path. Empty and "." components are dropped, ".." pops one stacked component, and
// any other component is written straight into the component store (16 slots of
// 32 bytes) as its bytes arrive, so a path byte is taken every cycle unless stalled.
// After the last byte, a command goes through a two-entry queue to the back, which
// answers on rsp_if: the normalized path one byte per cycle, a single "/" for an
// empty stack, or one error result (byte 0, status 1) for an invalid or too long
// path. end_of_path marks the final result of each path.
// A single result goes from the command queue to the response register; a walked
// path goes from the queue through the back's slash or read stage to the response
// register and then streams one byte per cycle, set by the single read port of the store.
// From the last byte until the back has read the store, req_if.ready stays low.
// csr_write_enable writes out_capacity (reset value 64); the user must use it only
// while the block is idle, which the block does not enforce. Reset is synchronous
// and the store needs no clearing pass. A stalled receiver holds the response and
// pauses the walk. Depends on apn_pkg, apn_req_if, apn_rsp_if, apn_ram, apn_front,
// apn_cmd_queue and apn_back.
`default_nettype none

module absolute_path_normalizer
   import apn_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [CAP_W-1:0] csr_write_data,
   apn_req_if.sink               req_if,
   apn_rsp_if.source             rsp_if
);

   logic [CAP_W-1:0]  out_capacity_ff, out_capacity_in;
   store_wr_type      store_wr;
   store_rd_type      store_rd;
   logic [BYTE_W-1:0] store_rd_data;
   logic              cmd_push;
   cmd_type           push_cmd;
   cmd_type           pop_cmd;
   logic              cmd_pop;
   q_status_type      q_status;
   logic [SLOT_W-1:0] len_rd_slot;
   logic [LEN_W-1:0]  len_rd_len;
   logic              back_busy;
   logic              front_stall;

   assign out_capacity_in = csr_write_enable ? csr_write_data : out_capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_capacity_ff <= CAP_RESET;
      end else begin
         out_capacity_ff <= out_capacity_in;
      end
   end

   // The front waits while a command is queued or the back is reading the store,
   // so the next path never overwrites slots that are still being emitted.
   assign front_stall = back_busy || q_status.valid;

   apn_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .stall        (front_stall),
      .out_capacity (out_capacity_ff),
      .store_wr     (store_wr),
      .cmd_push     (cmd_push),
      .cmd          (push_cmd),
      .len_rd_slot  (len_rd_slot),
      .len_rd_len   (len_rd_len)
   );

   apn_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   apn_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr.en),
      .wr_addr (store_wr.addr),
      .wr_data (store_wr.data),
      .rd_en   (store_rd.en),
      .rd_addr (store_rd.addr),
      .rd_data (store_rd_data)
   );

   apn_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (q_status.valid),
      .cmd           (pop_cmd),
      .cmd_pop       (cmd_pop),
      .len_rd_slot   (len_rd_slot),
      .len_rd_len    (len_rd_len),
      .store_rd      (store_rd),
      .store_rd_data (store_rd_data),
      .busy          (back_busy),
      .rsp_if        (rsp_if)
   );

   // The store is never written while the back is reading it.
   assert property (@(posedge clock) disable iff (reset)
      !(store_wr.en && store_rd.en))
      else $error("store written during a walk");

   // A finished path never finds the command queue full.
   assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !q_status.full)
      else $error("command queue overflow");

   // An error result is a single zero byte that also ends the path.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status) |-> ((rsp_if.out_byte == ERROR_BYTE) &&
                                           rsp_if.end_of_path))
      else $error("malformed error result");

   // No request is taken while the back still walks the store.
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |-> !back_busy)
      else $error("request taken during a walk");

endmodule

`default_nettype wire
